/* rtl/assert_macros.svh */
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* rtl/mrf_pkg.sv */
// Types, constants and CRC step function of the Modbus RTU request framer.
`timescale 1ns / 1ps
package mrf_pkg;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h01;

  typedef logic [2:0] byte_idx_t;

  // byte positions inside the eight-byte frame
  localparam byte_idx_t IDX_SLAVE   = 3'd0;
  localparam byte_idx_t IDX_FUNC    = 3'd1;
  localparam byte_idx_t IDX_REG_HI  = 3'd2;
  localparam byte_idx_t IDX_REG_LO  = 3'd3;
  localparam byte_idx_t IDX_OPND_HI = 3'd4;
  localparam byte_idx_t IDX_OPND_LO = 3'd5;
  localparam byte_idx_t IDX_CRC_LO  = 3'd6;
  localparam byte_idx_t IDX_CRC_HI  = 3'd7;

  typedef enum logic {
    REQ_READ_HOLDING = 1'b0,
    REQ_WRITE_SINGLE = 1'b1
  } req_type_t;

  // one queued request, already classified
  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] opnd;
  } mrf_req_t;

  // reflected CRC-16 update over one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

/* rtl/mrf_in_if.sv */
// Request channel interface: valid/ready plus request fields.
`timescale 1ns / 1ps
interface mrf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] start_reg;
  logic [15:0] operand;

  modport source (output valid, output req_type, output start_reg,
                  output operand, input ready);
  modport sink   (input valid, input req_type, input start_reg,
                  input operand, output ready);
endinterface

/* rtl/mrf_out_if.sv */
// Frame byte channel interface: valid/ready plus one byte and last flag.
`timescale 1ns / 1ps
interface mrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* rtl/mrf_fifo.sv */
// Small register queue of classified requests between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrf_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrf_pkg::mrf_req_t push_data,
  output logic              full,
  input  logic              pop,
  output mrf_pkg::mrf_req_t head,
  output logic              head_valid
);
  import mrf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mrf_req_t          mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CntW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CntW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_CLK(a_fifo_count_bound, clk, rst_n, count_r <= CntW'(DEPTH), "queue count over depth")
  `ASSERT_NEVER(a_fifo_pop_empty, clk, rst_n, pop && !head_valid, "pop from empty queue")

endmodule

/* rtl/mrf_front.sv */
// Front end: holds the slave address, accepts requests and classifies them.
`timescale 1ns / 1ps
module mrf_front (
  input  logic              clk,
  input  logic              rst_n,
  mrf_in_if.sink            in_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output logic              q_push,
  output mrf_pkg::mrf_req_t q_data,
  input  logic              q_full
);
  import mrf_pkg::*;

  logic [7:0] slave_addr_r, slave_addr_nxt;
  logic [7:0] func;

  assign slave_addr_nxt = cfg_we ? cfg_wdata : slave_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RESET;
    end else begin
      slave_addr_r <= slave_addr_nxt;
    end
  end

  always_comb begin
    case (req_type_t'(in_ch.req_type))
      REQ_READ_HOLDING: func = FUNC_READ_HOLDING;
      REQ_WRITE_SINGLE: func = FUNC_WRITE_SINGLE;
      default:          func = FUNC_READ_HOLDING;
    endcase
  end

  assign in_ch.ready     = !q_full;
  assign q_push          = in_ch.valid && !q_full;
  assign q_data.slave    = slave_addr_r;
  assign q_data.func     = func;
  assign q_data.reg_addr = in_ch.start_reg;
  assign q_data.opnd     = in_ch.operand;

endmodule

/* rtl/mrf_back.sv */
// Back end: serializes one queued request into eight bytes with running CRC.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mrf_pkg::mrf_req_t head,
  input  logic              head_valid,
  output logic              pop,
  mrf_out_if.source         out_ch
);
  import mrf_pkg::*;

  byte_idx_t   idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  sel_byte;
  logic        load;

  always_comb begin
    case (idx_r)
      IDX_SLAVE:   sel_byte = head.slave;
      IDX_FUNC:    sel_byte = head.func;
      IDX_REG_HI:  sel_byte = head.reg_addr[15:8];
      IDX_REG_LO:  sel_byte = head.reg_addr[7:0];
      IDX_OPND_HI: sel_byte = head.opnd[15:8];
      IDX_OPND_LO: sel_byte = head.opnd[7:0];
      IDX_CRC_LO:  sel_byte = crc_r[7:0];
      IDX_CRC_HI:  sel_byte = crc_r[15:8];
      default:     sel_byte = '0;
    endcase
  end

  // output register is free or drains this cycle
  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && (idx_r == IDX_CRC_HI);

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = sel_byte;
      last_nxt      = (idx_r == IDX_CRC_HI);
      idx_nxt       = byte_idx_t'(idx_r + 1'b1);
      if (idx_r == IDX_CRC_HI) begin
        crc_nxt = CRC_INIT;
      end else if (idx_r != IDX_CRC_LO) begin
        crc_nxt = crc16_byte(crc_r, sel_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= IDX_SLAVE;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = byte_r;
  assign out_ch.last_byte  = last_r;

  `ASSERT_CLK(a_back_head_mid_frame, clk, rst_n, (idx_r != IDX_SLAVE) |-> head_valid, "request left queue mid frame")
  `ASSERT_CLK(a_back_last_wraps, clk, rst_n, (out_valid_r && last_r) |-> (idx_r == IDX_SLAVE), "last byte shown but byte index not wrapped")

endmodule

/* rtl/modbus_rtu_request_framer.sv */
// Top level of the Modbus RTU master request framer.
`timescale 1ns / 1ps
// Usage:
//   in_ch   request beats: req_type (0 read holding regs, 1 write single reg),
//           start_reg and operand. Accepted when valid && ready.
//   out_ch  frame beats, one byte each: slave address, function code,
//           register address hi/lo, operand hi/lo, CRC-16/Modbus lo/hi.
//           last_byte marks the eighth beat.
//   cfg_*   cfg_we writes cfg_wdata into the slave address (reset value 1).
//           The address is sampled when a request is accepted.
// Path: the first byte of a frame reaches out_ch from an accepted request
//   beat through the queue write, then the output register.
// Throughput: one byte per cycle while out_ch.ready is high; the output
//   register serializer sets this. The CRC runs one byte per cycle alongside
//   the serializer, so frames follow each other with no gap.
// Stalls: the output register holds while out_ch.ready is low; the request
//   queue (QUEUE_DEPTH entries) keeps accepting until it fills.
// Reset: synchronous, active low; empties the queue and the output register.
module modbus_rtu_request_framer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  mrf_in_if.sink     in_ch,
  mrf_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import mrf_pkg::*;

  mrf_req_t q_data;
  mrf_req_t q_head;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;

  // front: slave address register, classification into function codes
  mrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  // decoupling queue
  mrf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  // back: byte serializer with running CRC
  mrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
